@@ design/tmsw_pkg.sv @@
package tmsw_pkg;

    // fixed field widths of the request and result channels
    localparam int CMD_W    = 2;
    localparam int CODE_W   = 9;
    localparam int CURSOR_W = 11;
    localparam int DATA_W   = 16;
    localparam int ATTR_W   = 8;
    localparam int CHAR_W   = 8;

    localparam logic [CMD_W-1:0] CMD_PUT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic [CODE_W-1:0] CODE_NEWLINE   = 9'd10;
    localparam logic [CODE_W-1:0] CODE_BACKSPACE = 9'd256;
    localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET     = 8'h07;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

@@ design/tmsw_ram.sv @@
module tmsw_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic                        i_clk,
    input  tmsw_pkg::t_mem_ctl          i_mem_ctl,
    input  logic [AW-1:0]               i_waddr,
    input  logic [tmsw_pkg::DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [tmsw_pkg::DATA_W-1:0] o_rdata
);

    logic [tmsw_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [tmsw_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_mem_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_mem_ctl.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/tmsw_ctrl.sv @@
module tmsw_ctrl #(
    parameter int COLUMNS     = 80,
    parameter int SCROLL_ROW  = 24,
    parameter int SCREEN_ROWS = 25,
    parameter int TOTAL       = SCREEN_ROWS * COLUMNS,
    parameter int AW          = $clog2(TOTAL),
    parameter int PW          = $clog2(TOTAL + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [tmsw_pkg::ATTR_W-1:0]   i_attr,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [tmsw_pkg::CMD_W-1:0]    i_command,
    input  logic [tmsw_pkg::CODE_W-1:0]   i_char_code,
    input  logic [tmsw_pkg::CURSOR_W-1:0] i_cell_index,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output logic [PW-1:0]                 o_res_cursor,
    output logic [tmsw_pkg::DATA_W-1:0]   o_res_data,
    output tmsw_pkg::t_mem_ctl            o_mem_ctl,
    output logic [AW-1:0]                 o_mem_waddr,
    output logic [tmsw_pkg::DATA_W-1:0]   o_mem_wdata,
    output logic [AW-1:0]                 o_mem_raddr,
    input  logic [tmsw_pkg::DATA_W-1:0]   i_mem_rdata
);

    localparam int RW           = $clog2(SCREEN_ROWS + 1);
    localparam int SCROLL_START = SCROLL_ROW * COLUMNS;
    localparam int MOVED        = (SCROLL_ROW - 1) * COLUMNS;
    localparam int COPY_LEN     = (MOVED < TOTAL - COLUMNS) ? MOVED : TOTAL - COLUMNS;
    localparam int ZERO_END     = (SCROLL_START < TOTAL) ? SCROLL_START : TOTAL;
    // row = (pos * DIV_M) >> DIV_K, exact for every pos below 2**PW
    localparam int DIV_K        = PW + $clog2(COLUMNS);
    localparam int DIV_M        = ((2 ** DIV_K) + COLUMNS - 1) / COLUMNS;
    localparam int MW           = $clog2(DIV_M + 1);

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_DIV   = 10'b0000000100,
        S_NL    = 10'b0000001000,
        S_CHECK = 10'b0000010000,
        S_COPY  = 10'b0000100000,
        S_ZERO  = 10'b0001000000,
        S_FINAL = 10'b0010000000,
        S_READ  = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

    t_state                        r_state;
    t_state                        n_state;
    logic [PW-1:0]                 r_addr;
    logic [PW-1:0]                 r_pos;
    logic [PW-1:0]                 r_cursor;
    logic [RW-1:0]                 r_row;
    logic [tmsw_pkg::DATA_W-1:0]   r_data;

    logic                          accept;
    logic                          idx_in_range;
    logic                          is_newline;
    logic                          is_backspace;
    logic [PW-1:0]                 idx_sat;
    logic [PW+MW-1:0]              div_prod;
    logic [PW-1:0]                 nl_pos;
    logic [PW-1:0]                 sat_pos;
    logic [PW-1:0]                 copy_src;
    logic [PW-1:0]                 copy_dst;
    logic                          do_scroll;
    logic                          copy_rd;
    logic                          zero_more;

    assign o_ready      = (r_state == S_IDLE);
    assign accept       = i_valid && o_ready;
    assign idx_in_range = 32'(i_cell_index) < TOTAL;
    assign is_newline   = (i_char_code == tmsw_pkg::CODE_NEWLINE);
    assign is_backspace = (i_char_code == tmsw_pkg::CODE_BACKSPACE);
    assign idx_sat      = idx_in_range ? PW'(i_cell_index) : PW'(TOTAL - 1);
    assign div_prod     = (PW+MW)'(r_pos) * (PW+MW)'(DIV_M);
    assign nl_pos       = PW'((32'(r_row) + 32'd1) * 32'(COLUMNS));
    assign sat_pos      = (32'(r_pos) >= TOTAL) ? PW'(TOTAL - 1) : r_pos;
    assign copy_src     = r_addr + PW'(COLUMNS);
    assign copy_dst     = r_addr - PW'(1);
    assign do_scroll    = 32'(r_pos) >= SCROLL_START;
    assign copy_rd      = 32'(r_addr) < COPY_LEN;
    assign zero_more    = 32'(r_addr) < ZERO_END;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (32'(r_addr) == TOTAL - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    case (i_command)
                        tmsw_pkg::CMD_PUT: n_state = is_newline ? S_DIV : S_CHECK;
                        tmsw_pkg::CMD_READ: n_state = idx_in_range ? S_READ : S_DONE;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_DIV:   n_state = S_NL;
            S_NL:    n_state = S_CHECK;
            S_CHECK: n_state = do_scroll ? S_COPY : S_FINAL;
            S_COPY: begin
                if (!copy_rd) begin
                    n_state = S_ZERO;
                end
            end
            S_ZERO: begin
                if (!zero_more) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: n_state = S_DONE;
            S_READ:  n_state = S_DONE;
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_addr   <= '0;
            r_cursor <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_CLEAR: r_addr <= r_addr + PW'(1);
                S_IDLE: begin
                    if (accept) begin
                        r_data <= '0;
                        if (i_command == tmsw_pkg::CMD_SET) begin
                            r_cursor <= idx_sat;
                        end
                        if (is_newline) begin
                            r_pos <= r_cursor;
                        end else if (is_backspace) begin
                            r_pos <= (r_cursor == '0) ? '0 : r_cursor - PW'(1);
                        end else begin
                            r_pos <= r_cursor + PW'(1);
                        end
                    end
                end
                S_DIV: r_row <= RW'(div_prod >> DIV_K);
                S_NL:  r_pos <= nl_pos;
                S_CHECK: begin
                    if (do_scroll) begin
                        r_pos  <= r_pos - PW'(COLUMNS);
                        r_addr <= '0;
                    end
                end
                S_COPY: begin
                    // copy finished: sweep the zero fill from the new cursor
                    r_addr <= copy_rd ? r_addr + PW'(1) : r_pos;
                end
                S_ZERO: begin
                    if (zero_more) begin
                        r_addr <= r_addr + PW'(1);
                    end
                end
                S_FINAL: r_cursor <= sat_pos;
                S_READ:  r_data <= i_mem_rdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_mem_ctl   = '0;
        o_mem_waddr = '0;
        o_mem_wdata = '0;
        o_mem_raddr = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_mem_ctl.wr_en = 1'b1;
                o_mem_waddr     = r_addr[AW-1:0];
            end
            S_IDLE: begin
                if (i_valid) begin
                    if (i_command == tmsw_pkg::CMD_PUT && !is_newline && !is_backspace) begin
                        o_mem_ctl.wr_en = 1'b1;
                        o_mem_waddr     = r_cursor[AW-1:0];
                        o_mem_wdata     = {i_attr, i_char_code[tmsw_pkg::CHAR_W-1:0]};
                    end else if (i_command == tmsw_pkg::CMD_READ && idx_in_range) begin
                        o_mem_ctl.rd_en = 1'b1;
                        o_mem_raddr     = AW'(i_cell_index);
                    end
                end
            end
            S_COPY: begin
                // read one row ahead, write back the cell read last cycle
                if (copy_rd) begin
                    o_mem_ctl.rd_en = 1'b1;
                    o_mem_raddr     = copy_src[AW-1:0];
                end
                if (r_addr != '0) begin
                    o_mem_ctl.wr_en = 1'b1;
                    o_mem_waddr     = copy_dst[AW-1:0];
                    o_mem_wdata     = i_mem_rdata;
                end
            end
            S_ZERO: begin
                if (zero_more) begin
                    o_mem_ctl.wr_en = 1'b1;
                    o_mem_waddr     = r_addr[AW-1:0];
                end
            end
            S_FINAL: begin
                o_mem_ctl.wr_en = 1'b1;
                o_mem_waddr     = sat_pos[AW-1:0];
                o_mem_wdata     = {i_attr, tmsw_pkg::CHAR_SPACE};
            end
            default: ;
        endcase
    end

    assign o_res_valid  = (r_state == S_DONE);
    assign o_res_cursor = r_cursor;
    assign o_res_data   = r_data;

endmodule

@@ design/text_mode_screen_writer_unit.sv @@
// channel    | direction | handshake         | payload
// request    | in        | i_valid / o_ready | i_command, i_char_code, i_cell_index
// result     | out       | o_valid / i_ready | o_cursor_pos, o_read_data
// attribute  | in        | i_cfg_wr_en       | i_cfg_wr_data
//
// set cursor, unused command and read past the screen go straight to the result; read cell
//   registers the memory read; newline first computes the row; put char writes a space at the cursor
// a scroll then copies (SCROLL_ROW-1)*COLUMNS cells up one row through the single write port
//   of the screen memory, then clears the cells from the new cursor to the scroll row (up to COLUMNS)
// after reset a clearing pass writes SCREEN_ROWS*COLUMNS cells, one per cycle, with o_ready low
// a result waits in the output register while the next request is accepted
module text_mode_screen_writer_unit #(
    parameter int COLUMNS     = 80,
    parameter int SCROLL_ROW  = 24,
    parameter int SCREEN_ROWS = 25
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [tmsw_pkg::ATTR_W-1:0]   i_cfg_wr_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [tmsw_pkg::CMD_W-1:0]    i_command,
    input  logic [tmsw_pkg::CODE_W-1:0]   i_char_code,
    input  logic [tmsw_pkg::CURSOR_W-1:0] i_cell_index,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [tmsw_pkg::CURSOR_W-1:0] o_cursor_pos,
    output logic [tmsw_pkg::DATA_W-1:0]   o_read_data
);

    localparam int TOTAL = SCREEN_ROWS * COLUMNS;
    localparam int AW    = $clog2(TOTAL);
    localparam int PW    = $clog2(TOTAL + 1);
    localparam int CUR_W = tmsw_pkg::CURSOR_W;

    logic [tmsw_pkg::ATTR_W-1:0]   r_attr;
    logic                          r_out_valid;
    logic [CUR_W-1:0]              r_out_cursor;
    logic [tmsw_pkg::DATA_W-1:0]   r_out_data;

    logic                          res_valid;
    logic                          res_ready;
    logic [PW-1:0]                 res_cursor;
    logic [tmsw_pkg::DATA_W-1:0]   res_data;
    tmsw_pkg::t_mem_ctl            mem_ctl;
    logic [AW-1:0]                 mem_waddr;
    logic [tmsw_pkg::DATA_W-1:0]   mem_wdata;
    logic [AW-1:0]                 mem_raddr;
    logic [tmsw_pkg::DATA_W-1:0]   mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= tmsw_pkg::ATTR_RESET;
        end else if (i_cfg_wr_en) begin
            r_attr <= i_cfg_wr_data;
        end
    end

    tmsw_ctrl #(
        .COLUMNS     (COLUMNS),
        .SCROLL_ROW  (SCROLL_ROW),
        .SCREEN_ROWS (SCREEN_ROWS),
        .TOTAL       (TOTAL),
        .AW          (AW),
        .PW          (PW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_attr       (r_attr),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_command    (i_command),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res_cursor (res_cursor),
        .o_res_data   (res_data),
        .o_mem_ctl    (mem_ctl),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata)
    );

    tmsw_ram #(
        .DEPTH (TOTAL),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_mem_ctl (mem_ctl),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr   (mem_raddr),
        .o_rdata   (mem_rdata)
    );

    // output register: free, or being emptied this cycle
    assign res_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out_cursor <= CUR_W'(res_cursor);
            r_out_data   <= res_data;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_cursor_pos = r_out_cursor;
    assign o_read_data  = r_out_data;

endmodule

@@ design/tmsw_checker.sv @@
module tmsw_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [tmsw_pkg::CURSOR_W-1:0] o_cursor_pos,
    input logic [tmsw_pkg::DATA_W-1:0]   o_read_data
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_cursor_pos) && $stable(o_read_data))
        else $error("result changed while stalled");

    // the clearing pass keeps requests out right after reset
    a_reset_not_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready)
        else $error("request ready during screen clear");

    a_reset_no_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // one request in work at a time
    a_one_at_a_time: assert property (@(posedge i_clk)
        i_valid && o_ready |=> !o_ready)
        else $error("second request taken while busy");

endmodule

bind text_mode_screen_writer_unit tmsw_checker u_tmsw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_cursor_pos (o_cursor_pos),
    .o_read_data  (o_read_data)
);

@@ bench/text_mode_screen_writer_unit_tb.sv @@
`timescale 1ns / 1ps

module text_mode_screen_writer_unit_tb;

    localparam int COLS   = 80;
    localparam int SCROLL = 24;
    localparam int ROWS   = 25;
    localparam int CELLS  = ROWS * COLS;
    localparam int CUR_W  = tmsw_pkg::CURSOR_W;
    localparam int DAT_W  = tmsw_pkg::DATA_W;
    localparam int ATT_W  = tmsw_pkg::ATTR_W;
    localparam int CMD_W  = tmsw_pkg::CMD_W;
    localparam int CODE_W = tmsw_pkg::CODE_W;

    typedef struct packed {
        logic [CUR_W-1:0] cursor_pos;
        logic [DAT_W-1:0] read_data;
    } t_screen_result;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_wr_en   = 1'b0;
    logic [ATT_W-1:0]  i_cfg_wr_data = '0;
    logic              i_valid       = 1'b0;
    logic              o_ready;
    logic [CMD_W-1:0]  i_command     = tmsw_pkg::CMD_PUT;
    logic [CODE_W-1:0] i_char_code   = '0;
    logic [CUR_W-1:0]  i_cell_index  = '0;
    logic              o_valid;
    logic              i_ready       = 1'b0;
    logic [CUR_W-1:0]  o_cursor_pos;
    logic [DAT_W-1:0]  o_read_data;

    // shadow copy of the screen, cursor and attribute
    logic [DAT_W-1:0] screen_model [CELLS];
    int unsigned      cursor_model = 0;
    logic [ATT_W-1:0] attr_model   = tmsw_pkg::ATTR_RESET;

    t_screen_result pending_results [$];
    t_screen_result oldest;
    int             fail_count  = 0;
    int             tx_idle_pct = 0;
    int             rx_idle_pct = 0;
    int unsigned    hold_req    = 0;
    int unsigned    hold_ack    = 0;
    int unsigned    hold_left   = 0;

    text_mode_screen_writer_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_command     (i_command),
        .i_char_code   (i_char_code),
        .i_cell_index  (i_cell_index),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_cursor_pos  (o_cursor_pos),
        .o_read_data   (o_read_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        foreach (screen_model[k]) screen_model[k] = '0;
    end

    function automatic void write_char(input logic [CODE_W-1:0] code);
        int unsigned pos;
        int unsigned k;
        pos = cursor_model;
        if (code == tmsw_pkg::CODE_NEWLINE) begin
            pos = pos + COLS - pos % COLS;
        end else if (code == tmsw_pkg::CODE_BACKSPACE) begin
            if (pos > 0) pos = pos - 1;
        end else begin
            screen_model[pos] = {attr_model, code[tmsw_pkg::CHAR_W-1:0]};
            pos = pos + 1;
        end
        if (pos / COLS >= SCROLL) begin
            for (k = 0; k < (SCROLL - 1) * COLS; k++) screen_model[k] = screen_model[k + COLS];
            pos = pos - COLS;
            // clear is empty when the cursor sits past the end of the last scrolled row
            for (k = pos; k < SCROLL * COLS; k++) screen_model[k] = '0;
        end
        if (pos >= CELLS) pos = CELLS - 1;
        cursor_model = pos;
        screen_model[pos] = {attr_model, tmsw_pkg::CHAR_SPACE};
    endfunction

    function automatic t_screen_result console_step(input logic [CMD_W-1:0] cmd,
                                                    input logic [CODE_W-1:0] code,
                                                    input logic [CUR_W-1:0] idx);
        t_screen_result r;
        r.read_data = '0;
        case (cmd)
            tmsw_pkg::CMD_PUT: write_char(code);
            tmsw_pkg::CMD_SET: cursor_model = (idx >= CELLS) ? CELLS - 1 : idx;
            tmsw_pkg::CMD_READ: begin
                if (idx < CELLS) r.read_data = screen_model[idx];
            end
            default: ;
        endcase
        r.cursor_pos = CUR_W'(cursor_model);
        return r;
    endfunction

    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [CODE_W-1:0] code,
                                input logic [CUR_W-1:0] idx);
        if ($urandom_range(99, 0) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_command    <= cmd;
        i_char_code  <= code;
        i_cell_index <= idx;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        pending_results.push_back(console_step(cmd, code, idx));
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_attribute(input logic [ATT_W-1:0] value);
        drain_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        attr_model = value;
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_ack != hold_req) begin
            hold_ack  <= hold_req;
            hold_left <= 400;
            i_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99, 0) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request pending: cursor_pos %0d read_data %h",
                       o_cursor_pos, o_read_data);
                fail_count++;
            end else begin
                oldest = pending_results.pop_front();
                if (o_cursor_pos !== oldest.cursor_pos) begin
                    $error("cursor_pos expected %0d actual %0d", oldest.cursor_pos, o_cursor_pos);
                    fail_count++;
                end
                if (o_read_data !== oldest.read_data) begin
                    $error("read_data expected %h actual %h", oldest.read_data, o_read_data);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_reset_state();
        send_request(tmsw_pkg::CMD_READ, '0, 11'd0);
        send_request(tmsw_pkg::CMD_READ, '1, 11'd1999);
        send_request(tmsw_pkg::CMD_READ, '0, 11'd2047);
    endtask

    task automatic test_character_codes();
        send_request(tmsw_pkg::CMD_PUT, 9'd65, 11'd0);
        send_request(tmsw_pkg::CMD_PUT, 9'd0, 11'h7FF);
        send_request(tmsw_pkg::CMD_PUT, 9'd255, 11'd0);
        send_request(tmsw_pkg::CMD_PUT, 9'd257, 11'd0);
        send_request(tmsw_pkg::CMD_PUT, 9'd511, 11'd0);
        send_request(tmsw_pkg::CMD_PUT, tmsw_pkg::CODE_BACKSPACE, 11'd0);
        send_request(tmsw_pkg::CMD_PUT, tmsw_pkg::CODE_NEWLINE, 11'd0);
        send_request(tmsw_pkg::CMD_READ, '0, 11'd0);
        send_request(tmsw_pkg::CMD_READ, '0, 11'd4);
    endtask

    task automatic test_cursor_limits();
        send_request(tmsw_pkg::CMD_SET, '0, 11'd0);
        // backspace at the home position stays put
        send_request(tmsw_pkg::CMD_PUT, tmsw_pkg::CODE_BACKSPACE, 11'd0);
        send_request(tmsw_pkg::CMD_SET, '0, 11'd2047);
        send_request(tmsw_pkg::CMD_READ, '0, 11'd1999);
    endtask

    task automatic test_scroll();
        // last cell: scroll with nothing to clear
        send_request(tmsw_pkg::CMD_PUT, 9'd88, 11'd0);
        send_request(tmsw_pkg::CMD_READ, '0, 11'd1999);
        send_request(tmsw_pkg::CMD_SET, '0, 11'd1919);
        send_request(tmsw_pkg::CMD_PUT, 9'd89, 11'd0);
        send_request(tmsw_pkg::CMD_SET, '0, 11'd1850);
        send_request(tmsw_pkg::CMD_PUT, tmsw_pkg::CODE_NEWLINE, 11'd0);
        send_request(tmsw_pkg::CMD_READ, '0, 11'd1760);
    endtask

    task automatic test_unused_command();
        send_request(tmsw_pkg::CMD_UNUSED, 9'h1FF, 11'h7FF);
    endtask

    task automatic test_backpressure();
        int n;
        tx_idle_pct = 0;
        hold_req    = hold_req + 1;
        for (n = 0; n < 16; n++) begin
            case (n % 3)
                0: send_request(tmsw_pkg::CMD_SET, 9'($urandom), 11'($urandom));
                1: send_request(tmsw_pkg::CMD_READ, 9'($urandom), 11'($urandom));
                default: send_request(tmsw_pkg::CMD_PUT, 9'($urandom_range(126, 32)),
                                      11'($urandom));
            endcase
        end
        // sender waits for everything to come back before going on
        drain_results();
        send_request(tmsw_pkg::CMD_READ, '0, CUR_W'(cursor_model));
    endtask

    task automatic random_batch(input int n_items);
        int                sent;
        int                pick;
        logic [CMD_W-1:0]  cmd;
        logic [CODE_W-1:0] code;
        logic [CUR_W-1:0]  idx;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99, 0);
            if (pick < 70) begin
                // a line of text, often placed near the bottom rows
                if ($urandom_range(1, 0)) begin
                    if ($urandom_range(1, 0)) idx = CUR_W'($urandom_range(2047, 1760));
                    else idx = CUR_W'($urandom);
                    send_request(tmsw_pkg::CMD_SET, 9'($urandom), idx);
                    sent++;
                end
                repeat ($urandom_range(20, 4)) begin
                    case ($urandom_range(19, 0))
                        0: code = tmsw_pkg::CODE_NEWLINE;
                        1: code = tmsw_pkg::CODE_BACKSPACE;
                        2: code = 9'($urandom);
                        default: code = 9'($urandom_range(126, 32));
                    endcase
                    send_request(tmsw_pkg::CMD_PUT, code, 11'($urandom));
                    sent++;
                end
            end else if (pick < 85) begin
                case ($urandom_range(2, 0))
                    0: idx = CUR_W'((cursor_model + $urandom_range(6, 0) + CELLS - 3) % CELLS);
                    1: idx = CUR_W'($urandom_range(2047, 1760));
                    default: idx = CUR_W'($urandom);
                endcase
                send_request(tmsw_pkg::CMD_READ, 9'($urandom), idx);
                sent++;
            end else begin
                cmd = CMD_W'($urandom);
                send_request(cmd, 9'($urandom), 11'($urandom));
                if (cmd != tmsw_pkg::CMD_UNUSED) sent++;
            end
        end
    endtask

    task automatic test_random_traffic();
        set_attribute(8'h00);
        tx_idle_pct = 10;
        rx_idle_pct = 50;
        random_batch(100);
        set_attribute(8'hFF);
        tx_idle_pct = 50;
        rx_idle_pct = 10;
        random_batch(100);
        set_attribute(ATT_W'($urandom));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_batch(100);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tx_idle_pct = 10;
        rx_idle_pct = 50;
        test_reset_state();
        test_character_codes();
        test_cursor_limits();
        test_scroll();
        test_unused_command();
        test_backpressure();
        test_random_traffic();
        drain_results();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
design/tmsw_pkg.sv
design/tmsw_ram.sv
design/tmsw_ctrl.sv
design/text_mode_screen_writer_unit.sv
design/tmsw_checker.sv
bench/text_mode_screen_writer_unit_tb.sv
